@@ hdl/apq_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority queue package
// Shared widths, codes and the control and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH_DEF         = 8;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int VALUE_W           = 32;
  localparam int IN_PRIO_W         = 8;
  localparam int STATUS_W          = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rej_full;
    logic rej_empty;
    logic scan_start;
    logic rd_issue;
    logic rd_shift;
    logic shift_setup;
    logic del_done;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_end;
  } sts_t;

endpackage

@@ hdl/apq_channels.sv @@
// ----------------------------------------------------------------------------
// Priority queue channels
// Valid/ready channels for the operation beats and the result beats.
// ----------------------------------------------------------------------------
interface apq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [apq_pkg::VALUE_W-1:0]   item_value;
  logic        [apq_pkg::IN_PRIO_W-1:0] item_priority;

  modport source (output valid, output operation, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input operation, input item_value,
                  input item_priority, output ready);
endinterface

interface apq_out_if #(
  parameter int OCC_W = 4
);
  logic                                valid;
  logic                                ready;
  logic signed [apq_pkg::VALUE_W-1:0]  removed_value;
  logic        [apq_pkg::STATUS_W-1:0] status;
  logic        [OCC_W-1:0]             occupancy;

  modport source (output valid, output removed_value, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input removed_value, input status,
                  input occupancy, output ready);
endinterface

@@ hdl/apq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Priority queue controller
// Sequences insert, scan, shift and result hand-off for one operation at a
// time and owns the channel handshakes.
// ----------------------------------------------------------------------------
module apq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_operation,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  apq_pkg::sts_t sts,
  output apq_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SETUP,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == apq_pkg::OP_INSERT) begin
            cmd.ins      = !sts.full;
            cmd.rej_full = sts.full;
            state_nxt    = S_EMIT;
          end else if (sts.empty) begin
            cmd.rej_empty = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.idx_end) begin
          state_nxt = S_SETUP;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_SETUP: begin
        cmd.shift_setup = 1'b1;
        state_nxt       = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.idx_end) begin
          cmd.del_done = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.rd_shift = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/apq_dp.sv @@
// ----------------------------------------------------------------------------
// Priority queue datapath
// Entry memory, occupancy count, scan for the earliest highest priority,
// the down shift of later entries and the result registers.
// ----------------------------------------------------------------------------
module apq_dp #(
  parameter int DEPTH         = apq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = apq_pkg::PRIORITY_BITS_DEF,
  localparam int AW           = $clog2(DEPTH),
  localparam int CW           = $clog2(DEPTH + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [apq_pkg::VALUE_W-1:0]    in_item_value,
  input  logic        [apq_pkg::IN_PRIO_W-1:0]  in_item_priority,
  input  apq_pkg::cmd_t                         cmd,
  output apq_pkg::sts_t                         sts,
  output logic signed [apq_pkg::VALUE_W-1:0]    out_removed_value,
  output logic        [apq_pkg::STATUS_W-1:0]   out_status,
  output logic        [CW-1:0]                  out_occupancy
);

  localparam int EW = apq_pkg::VALUE_W + PRIORITY_BITS;

  logic [EW-1:0] mem [DEPTH];

  logic [CW-1:0]                count_r;
  logic [CW-1:0]                idx_r;
  logic [EW-1:0]                rd_data_r;
  logic [AW-1:0]                rd_tag_r;
  logic                         rd_vld_r;
  logic                         rd_shift_r;
  logic [PRIORITY_BITS-1:0]     best_pri_r;
  logic [apq_pkg::VALUE_W-1:0]  best_val_r;
  logic [AW-1:0]                best_idx_r;
  logic [apq_pkg::VALUE_W-1:0]  res_value_r;
  apq_pkg::status_t             res_status_r;
  logic [apq_pkg::VALUE_W-1:0]  out_value_r;
  apq_pkg::status_t             out_status_r;
  logic [CW-1:0]                out_occ_r;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [EW-1:0]                wr_data;
  logic [PRIORITY_BITS-1:0]     rd_pri;
  logic [apq_pkg::VALUE_W-1:0]  rd_val;
  logic                         take_best;

  assign sts.full    = (count_r == CW'(DEPTH));
  assign sts.empty   = (count_r == '0);
  assign sts.idx_end = (idx_r == count_r);

  assign rd_pri = rd_data_r[PRIORITY_BITS-1:0];
  assign rd_val = rd_data_r[EW-1:PRIORITY_BITS];

  assign take_best = rd_vld_r && !rd_shift_r &&
                     ((rd_tag_r == '0) || (rd_pri > best_pri_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {in_item_value, PRIORITY_BITS'(in_item_priority)};
    if (cmd.ins) begin
      wr_en = 1'b1;
    end else if (rd_vld_r && rd_shift_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_tag_r - AW'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cmd.ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.del_done) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.shift_setup) begin
      idx_r <= CW'(best_idx_r) + CW'(1);
    end else if (cmd.rd_issue) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.rd_issue) begin
      rd_tag_r   <= idx_r[AW-1:0];
      rd_shift_r <= cmd.rd_shift;
    end
    if (take_best) begin
      best_pri_r <= rd_pri;
      best_val_r <= rd_val;
      best_idx_r <= rd_tag_r;
    end
    if (cmd.ins) begin
      res_value_r  <= '0;
      res_status_r <= apq_pkg::ST_OK;
    end else if (cmd.rej_full) begin
      res_value_r  <= '0;
      res_status_r <= apq_pkg::ST_FULL;
    end else if (cmd.rej_empty) begin
      res_value_r  <= '0;
      res_status_r <= apq_pkg::ST_EMPTY;
    end else if (cmd.del_done) begin
      res_value_r  <= best_val_r;
      res_status_r <= apq_pkg::ST_OK;
    end
    if (cmd.emit) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_removed_value = out_value_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occ_r;

endmodule

@@ hdl/array_priority_queue.sv @@
// Insert: once accepted, the result is registered in the emit state when the
// output register is free. Delete: the single read port of the entry memory
// reads one slot per cycle for the scan and one per cycle for the down shift.
// One operation is in flight at a time.
// Reset (synchronous, rst_n low) empties the queue; entry contents are kept.
// ----------------------------------------------------------------------------
// Array priority queue
// Fixed-depth queue of value and priority pairs kept in arrival order; a
// delete removes the earliest entry with the highest priority.
// ----------------------------------------------------------------------------
module array_priority_queue #(
  parameter int DEPTH         = apq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = apq_pkg::PRIORITY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  apq_in_if.sink        in_ch,
  apq_out_if.source     out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  apq_pkg::cmd_t cmd;
  apq_pkg::sts_t sts;
  logic [CW-1:0] occupancy;

  apq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  apq_dp #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_item_value     (in_ch.item_value),
    .in_item_priority  (in_ch.item_priority),
    .cmd               (cmd),
    .sts               (sts),
    .out_removed_value (out_ch.removed_value),
    .out_status        (out_ch.status),
    .out_occupancy     (occupancy)
  );

  assign out_ch.occupancy = occupancy;

endmodule
